@@ sv/rlps_pkg.sv @@
// Shared types, constants and color helpers for the rainbow LED PWM serializer.
// No dependencies; every other file of the block except rlps_ram imports this package.
package rlps_pkg;

  // Command as it arrives on the input port.
  typedef struct packed {
    logic       kind;
    logic [8:0] hue;
  } cmd_t;

  // One serial byte and its end-of-frame flag.
  typedef struct packed {
    logic [7:0] spi_byte;
    logic       frame_end;
  } result_t;

  // Command codes.
  localparam logic KIND_SET_HUE = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // Classified command held in the queue: hue already split into a sector and
  // the remainder inside that sector.
  typedef struct packed {
    logic       kind;
    logic [2:0] sector;
    logic [5:0] rem;
  } entry_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int WORD_W      = 16;
  localparam int INIT_IDX_W  = 6;

  localparam logic [8:0] SECTOR_SPAN  = 9'd60;
  localparam logic [5:0] HUE_STEP     = 6'd10;
  localparam logic [5:0] PWM_LAST     = 6'h3E;
  localparam logic [4:0] CHANNEL_FULL = 5'd31;
  localparam logic [2:0] SECTOR_LAST  = 3'd5;
  localparam logic [3:0] SECTOR_WRAP  = 4'd6;

  // Fraction table: f = (32 * rem) / 60 for a remainder inside one sector.
  function automatic logic [4:0] fraction_entry(input int k);
    int v;
    begin
      v = (k * 8) / 15;
      fraction_entry = 5'(v);
    end
  endfunction

  typedef logic [4:0] frac_table_t [64];

  function automatic frac_table_t build_frac_table();
    frac_table_t t;
    begin
      for (int k = 0; k < 64; k++) begin
        t[k] = fraction_entry(k);
      end
      build_frac_table = t;
    end
  endfunction

  localparam frac_table_t FRAC_TABLE = build_frac_table();

  // Full-saturation color word for one sector and fraction, red in 15:11,
  // green in 10:6 and blue in 4:0.
  function automatic logic [WORD_W-1:0] colour_word(input logic [2:0] sector,
                                                    input logic [4:0] f);
    logic [4:0] q;
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    begin
      q = CHANNEL_FULL - f;
      case (sector)
        3'd0: begin r = CHANNEL_FULL; g = f;            b = 5'd0;         end
        3'd1: begin r = q;            g = CHANNEL_FULL; b = 5'd0;         end
        3'd2: begin r = 5'd0;         g = CHANNEL_FULL; b = f;            end
        3'd3: begin r = 5'd0;         g = q;            b = CHANNEL_FULL; end
        3'd4: begin r = f;            g = 5'd0;         b = CHANNEL_FULL; end
        default: begin r = CHANNEL_FULL; g = 5'd0;      b = q;            end
      endcase
      colour_word = {r, g, 1'b0, b};
    end
  endfunction

  // Power-up color pattern of the store.
  function automatic logic [WORD_W-1:0] init_word(input logic [INIT_IDX_W-1:0] idx);
    begin
      case (idx)
        6'd2:    init_word = 16'h0800;
        6'd3:    init_word = 16'h003F;
        default: init_word = 16'h0000;
      endcase
    end
  endfunction

  // On/off bits of one LED against the PWM counter: red, green, blue.
  function automatic logic [2:0] led_bits(input logic [WORD_W-1:0] w,
                                          input logic [5:0] cnt);
    logic [5:0] red;
    logic [5:0] grn;
    logic [5:0] blu;
    begin
      red = {w[15:11], 1'b0};
      grn = w[10:5];
      blu = {w[4:0], 1'b0};
      led_bits = {red > cnt, grn > cnt, blu > cnt};
    end
  endfunction

endpackage

@@ sv/rlps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rlps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rlps_front.sv @@
// Front end: takes commands and reduces the hue to a sector and remainder.
// Depends on rlps_pkg.
module rlps_front
  import rlps_pkg::*;
(
  input  logic   start,
  input  logic   busy,
  input  cmd_t   cmd,
  output logic   push,
  output entry_t push_entry
);

  logic [3:0] sector_raw;
  logic [8:0] base;
  logic [8:0] rem_wide;

  // A transfer happens whenever start meets a free queue slot.
  assign push = start & ~busy;

  // Sector of the raw hue by threshold compares, then fold into 0..5.
  always_comb begin
    sector_raw = 4'd0;
    for (int k = 1; k <= 8; k++) begin
      if (cmd.hue >= 9'(k * 60)) begin
        sector_raw = 4'(k);
      end
    end
    base     = 9'(sector_raw) * SECTOR_SPAN;
    rem_wide = cmd.hue - base;
    push_entry.kind = cmd.kind;
    push_entry.rem  = rem_wide[5:0];
    if (sector_raw >= SECTOR_WRAP) begin
      push_entry.sector = 3'(sector_raw - SECTOR_WRAP);
    end else begin
      push_entry.sector = sector_raw[2:0];
    end
  end

endmodule

@@ sv/rlps_queue.sv @@
// Short FIFO of classified commands between the front and back ends.
// Depends on rlps_pkg.
module rlps_queue
  import rlps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   not_empty,
  output logic   full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ sv/rlps_back.sv @@
// Back end: rewrites the color store or streams one PWM frame per tick.
// Depends on rlps_pkg and rlps_ram.
module rlps_back
  import rlps_pkg::*;
#(
  parameter int LED_COUNT = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  entry_t  head,
  input  logic    not_empty,
  output logic    pop,
  output result_t result,
  output logic    result_valid
);

  localparam int IDX_W = $clog2(LED_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(LED_COUNT - 1);
  localparam logic [IDX_W-1:0] PAIR_LAST = IDX_W'((LED_COUNT / 2) * 2 - 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_SET,
    B_TICK
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic [2:0]        sector;
  logic [5:0]        rem;
  logic [5:0]        pwm_count;
  logic              loaded;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [2:0]        even_bits;

  logic [6:0]        rem_step;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] word;
  logic [2:0]        bits;
  logic              we;

  // Color store.
  rlps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LED_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  // Hue walk and color conversion for the LED being written. The step is one bit
  // wider than the remainder so that a remainder near the sector end does not wrap.
  assign rem_step = {1'b0, rem} + {1'b0, HUE_STEP};
  assign wdata    = colour_word(sector, FRAC_TABLE[rem]);
  assign we       = (state == B_SET);
  assign pop      = (state == B_IDLE) && not_empty;

  // Until the first rewrite the store reads as its power-up pattern.
  assign word = loaded ? rdata : init_word(INIT_IDX_W'(rd_idx));
  assign bits = led_bits(word, pwm_count);

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      idx          <= '0;
      pwm_count    <= '0;
      loaded       <= 1'b0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_valid <= (state == B_TICK);
      rd_idx   <= idx;

      case (state)
        B_IDLE: begin
          idx <= '0;
          if (not_empty) begin
            if (head.kind == KIND_SET_HUE) begin
              sector <= head.sector;
              rem    <= head.rem;
              state  <= B_SET;
            end else begin
              pwm_count <= (pwm_count == PWM_LAST) ? '0 : pwm_count + 1'b1;
              state     <= B_TICK;
            end
          end
        end
        B_SET: begin
          if (rem_step >= SECTOR_SPAN[6:0]) begin
            rem    <= 6'(rem_step - SECTOR_SPAN[6:0]);
            sector <= (sector == SECTOR_LAST) ? 3'd0 : sector + 1'b1;
          end else begin
            rem <= rem_step[5:0];
          end
          if (idx == IDX_LAST) begin
            loaded <= 1'b1;
            state  <= B_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        B_TICK: begin
          if (idx == PAIR_LAST) begin
            state <= B_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase

      // Pair the LEDs into bytes as read data returns.
      result_valid <= rd_valid && rd_idx[0];
      if (rd_valid) begin
        if (!rd_idx[0]) begin
          even_bits <= bits;
        end else begin
          result.spi_byte  <= {1'b0, even_bits, bits, 1'b0};
          result.frame_end <= (rd_idx == PAIR_LAST);
        end
      end
    end
  end

endmodule

@@ sv/rainbow_led_pwm_serializer_unit.sv @@
// Rainbow LED PWM serializer: a set_hue command makes one store write per LED in the
// back end; a tick makes one store read per paired LED on the single read port and
// gives one byte per pair of LEDs.
// With the back end idle, a tick's first byte passes the queue, the registered store read and the output register.
// busy is high while the two-entry command queue is full; the receiver cannot stall.
// Synchronous reset restores the power-up color pattern and clears the PWM counter.
module rainbow_led_pwm_serializer_unit
  import rlps_pkg::*;
#(
  parameter int LED_COUNT = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output result_t result,
  output logic    result_valid
);

  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   not_empty;

  // Command intake and hue reduction.
  rlps_front u_front (
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  rlps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (busy)
  );

  // Store update and frame streaming.
  rlps_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

@@ tb/rainbow_led_pwm_serializer_checker.sv @@
// Scoreboard for the rainbow LED PWM serializer: it follows the command and byte ports,
// keeps its own copy of the color store and the PWM counter, and compares every byte.
// Depends on rlps_pkg for the command and result types and the command codes.
module rainbow_led_pwm_serializer_checker
  import rlps_pkg::*;
#(
  parameter int LED_COUNT = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  result_t result,
  input  logic    result_valid,
  output int      mismatches,
  output int      outstanding,
  output int      bytes_checked,
  output int      hue_writes,
  output int      pwm_ticks
);

  // Shadow copy of the block state.
  logic [15:0] led_colour [LED_COUNT];
  logic [5:0]  pwm_level;

  // Bytes that the accepted ticks still owe, oldest first.
  result_t pending_bytes [$];

  // Full-saturation rainbow color for a hue of 0..359 degrees.
  function automatic logic [15:0] rainbow_word(input int unsigned deg);
    int unsigned sec;
    int unsigned frac;
    int unsigned comp;
    logic [4:0]  r;
    logic [4:0]  g;
    logic [4:0]  b;
    sec  = deg / 60;
    frac = (deg * 32) / 60 - 32 * sec;
    comp = 31 - frac;
    case (sec)
      0: begin
        r = 5'd31; g = 5'(frac); b = 5'd0;
      end
      1: begin
        r = 5'(comp); g = 5'd31; b = 5'd0;
      end
      2: begin
        r = 5'd0; g = 5'd31; b = 5'(frac);
      end
      3: begin
        r = 5'd0; g = 5'(comp); b = 5'd31;
      end
      4: begin
        r = 5'(frac); g = 5'd0; b = 5'd31;
      end
      default: begin
        r = 5'd31; g = 5'd0; b = 5'(comp);
      end
    endcase
    return (16'(r) << 11) | (16'(g) << 6) | 16'(b);
  endfunction

  // Red, green and blue on-bits of one LED for the current PWM level.
  function automatic logic [2:0] pwm_bits(input logic [15:0] w, input logic [5:0] level);
    int unsigned red_duty;
    int unsigned grn_duty;
    int unsigned blu_duty;
    red_duty = (int'(w) >> 10) & 'h3E;
    grn_duty = (int'(w) >> 5) & 'h3F;
    blu_duty = (int'(w) << 1) & 'h3E;
    return {red_duty > level, grn_duty > level, blu_duty > level};
  endfunction

  // Apply one accepted command to the shadow state and queue the bytes it causes.
  task automatic apply_command(input cmd_t c);
    result_t     exp_byte;
    int unsigned deg;
    if (c.kind == KIND_SET_HUE) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        deg           = (int'(c.hue) + 10 * i) % 360;
        led_colour[i] = rainbow_word(deg);
      end
      hue_writes <= hue_writes + 1;
    end else begin
      pwm_level = 6'((int'(pwm_level) + 1) % 'h3F);
      for (int i = 0; i + 1 < LED_COUNT; i += 2) begin
        exp_byte.spi_byte  = {1'b0, pwm_bits(led_colour[i], pwm_level),
                              pwm_bits(led_colour[i+1], pwm_level), 1'b0};
        exp_byte.frame_end = (i + 3 >= LED_COUNT);
        pending_bytes.push_back(exp_byte);
      end
      pwm_ticks <= pwm_ticks + 1;
    end
  endtask

  // Count a failure and describe the first few of them.
  task automatic report_mismatch(input string what, input result_t exp_byte,
                                 input result_t got_byte);
    if (mismatches < 10) begin
      $display("[%0t] %s: expected byte %02h end %0b, got byte %02h end %0b", $realtime,
               what, exp_byte.spi_byte, exp_byte.frame_end, got_byte.spi_byte,
               got_byte.frame_end);
    end
    mismatches <= mismatches + 1;
  endtask

  // Follow both ports at every rising edge; values are those settled before the edge.
  always @(posedge clk) begin
    result_t exp_byte;
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        case (i)
          2:       led_colour[i] = 16'h0800;
          3:       led_colour[i] = 16'h003F;
          default: led_colour[i] = 16'h0000;
        endcase
      end
      pwm_level = 6'd0;
      pending_bytes.delete();
      mismatches    <= 0;
      bytes_checked <= 0;
      hue_writes    <= 0;
      pwm_ticks     <= 0;
    end else begin
      if (start && !busy) begin
        apply_command(cmd);
      end
      if (result_valid) begin
        if (pending_bytes.size() == 0) begin
          exp_byte = '0;
          report_mismatch("byte with no tick behind it", exp_byte, result);
        end else begin
          exp_byte = pending_bytes.pop_front();
          if (result.spi_byte !== exp_byte.spi_byte ||
              result.frame_end !== exp_byte.frame_end) begin
            report_mismatch("serial byte differs", exp_byte, result);
          end
          bytes_checked <= bytes_checked + 1;
        end
      end
    end
    outstanding <= pending_bytes.size();
  end

endmodule

@@ tb/rainbow_led_pwm_serializer_unit_test.sv @@
// Top of the serializer testbench: clock, reset, command stimulus with random gaps, verdict.
// Depends on rlps_pkg, the rainbow_led_pwm_serializer_unit block and the checker module.
module rainbow_led_pwm_serializer_unit_test;
  import rlps_pkg::*;

  localparam int LED_COUNT = 8;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  result_t result;
  logic    result_valid;

  int mismatches;
  int outstanding;
  int bytes_checked;
  int hue_writes;
  int pwm_ticks;

  rainbow_led_pwm_serializer_unit #(.LED_COUNT(LED_COUNT)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result       (result),
    .result_valid (result_valid)
  );

  rainbow_led_pwm_serializer_checker #(.LED_COUNT(LED_COUNT)) scoreboard (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .result        (result),
    .result_valid  (result_valid),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .bytes_checked (bytes_checked),
    .hue_writes    (hue_writes),
    .pwm_ticks     (pwm_ticks)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Back-stop against a hung run.
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Present one command after a gap and hold it until the transfer happens.
  task automatic send_command(input logic kind, input logic [8:0] hue, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    cmd.kind <= kind;
    cmd.hue  <= hue;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending until every queued byte has come out.
  task automatic drain_bytes(input int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin
    int          gap;
    logic        kind;
    logic [8:0]  hue;
    bit          back_to_back;
    logic [8:0]  edge_hues [12];
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    edge_hues = '{9'd0, 9'd359, 9'd360, 9'd511, 9'd59, 9'd60, 9'd300, 9'd350, 9'd256,
                  9'd119, 9'd180, 9'd479};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: ticks on the power-up pattern, then boundary hues each followed by a tick.
    for (int i = 0; i < 3; i++) begin
      send_command(KIND_TICK, 9'd0, i);
    end
    foreach (edge_hues[i]) begin
      send_command(KIND_SET_HUE, edge_hues[i], 0);
      send_command(KIND_TICK, 9'h1FF, (i % 2) * 3);
    end
    drain_bytes(200);

    // Random part: mostly ticks so the counter wraps several times, hue writes in between.
    back_to_back = 1'b0;
    for (int n = 0; n < 245; n++) begin
      if (n % 20 == 0) begin
        back_to_back = ($urandom_range(0, 2) == 0);
      end
      if (n == 90 || n == 180) begin
        drain_bytes(200);
      end
      gap = back_to_back ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) begin
        kind = KIND_SET_HUE;
        hue  = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                           : 9'($urandom_range(0, 359));
      end else begin
        kind = KIND_TICK;
        hue  = 9'($urandom_range(0, 511));
      end
      send_command(kind, hue, gap);
    end

    // Let the last bytes out, then allow for the back end to settle.
    drain_bytes(5000);
    repeat (40) @(posedge clk);

    $display("Checked %0d serial bytes from %0d PWM ticks after %0d rainbow hue writes.",
             bytes_checked, pwm_ticks, hue_writes);
    $display("Mismatches: %0d, bytes still owed: %0d.", mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ rainbow_led_pwm_serializer_unit.f @@
sv/rlps_pkg.sv
sv/rlps_ram.sv
sv/rlps_front.sv
sv/rlps_queue.sv
sv/rlps_back.sv
sv/rainbow_led_pwm_serializer_unit.sv
tb/rainbow_led_pwm_serializer_checker.sv
tb/rainbow_led_pwm_serializer_unit_test.sv
